FILE: rtl/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam int MAX_RESULTS = 6;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RESULTS);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       at_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
    } result_t;

    // All results caused by one input byte
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [CNT_W-1:0]          count;
    } job_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } utf8_t;

    function automatic utf8_t cp_to_utf8(input logic [20:0] cp);
        utf8_t u;
        u = '0;
        if (cp < 21'h80) begin
            u.bytes[0] = cp[7:0];
            u.len      = 3'd1;
        end else if (cp < 21'h800) begin
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
            u.len      = 3'd2;
        end else if (cp < 21'h10000) begin
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
            u.len      = 3'd3;
        end else begin
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
            u.len      = 3'd4;
        end
        return u;
    endfunction

    function automatic job_t job_add(input job_t j, input logic [7:0] data,
                                     input logic [1:0] kind);
        job_t r;
        r = j;
        if (j.count < MAX_CNT) begin
            r.res[j.count].data = data;
            r.res[j.count].kind = kind;
            r.count             = j.count + 1'b1;
        end
        return r;
    endfunction

    function automatic job_t job_add_cp(input job_t j, input logic [20:0] cp);
        job_t  r;
        utf8_t u;
        r = j;
        u = cp_to_utf8(cp);
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < u.len) begin
                r = job_add(r, u.bytes[i], KIND_BYTE);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/jsu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    input  wire logic     q_full,
    output logic          push,
    output job_t          push_job
);

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_STR   = 4'd1;
    localparam logic [3:0] PH_ESC   = 4'd2;
    localparam logic [3:0] PH_HEX0  = 4'd3;
    localparam logic [3:0] PH_HEX3  = 4'd6;
    localparam logic [3:0] PH_AFTHI = 4'd7;
    localparam logic [3:0] PH_HIBSL = 4'd8;
    localparam logic [3:0] PH_PHEX0 = 4'd9;
    localparam logic [3:0] PH_PHEX3 = 4'd12;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] accum_reg, accum_next;
    logic [15:0] high_reg, high_next;
    logic        fire;

    // 4-bit value in [3:0], valid flag in [4]
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
        return {~r[4], r[3:0]};
    endfunction

    // mapped byte in [7:0], valid flag in [8]
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            default: r = 9'h000;
        endcase
        return r;
    endfunction

    assign s_ready = ~q_full;
    assign fire    = s_valid & s_ready;

    always_comb begin
        logic [7:0]  c;
        logic [4:0]  hd;
        logic [8:0]  esc;
        logic [15:0] v;
        logic        err;
        job_t        job;

        c          = s_data.in_byte;
        hd         = hex_digit(c);
        esc        = simple_escape(c);
        v          = {accum_reg[11:0], hd[3:0]};
        err        = 1'b0;
        job        = '0;
        phase_next = phase_reg;
        accum_next = accum_reg;
        high_next  = high_reg;

        if (s_data.at_end) begin
            err = 1'b1;
        end else begin
            unique case (phase_reg) inside
                PH_STR, PH_AFTHI: begin
                    if (phase_reg == PH_AFTHI && c == CH_BSL) begin
                        phase_next = PH_HIBSL;
                    end else begin
                        if (phase_reg == PH_AFTHI) begin
                            // Lone high surrogate: flush it
                            job        = job_add_cp(job, {5'd0, high_reg});
                            high_next  = '0;
                            phase_next = PH_STR;
                        end
                        if (c == CH_QUOTE) begin
                            job        = job_add(job, 8'd0, KIND_DONE);
                            phase_next = PH_IDLE;
                        end else if (c == CH_BSL) begin
                            phase_next = PH_ESC;
                        end else begin
                            job = job_add(job, c, KIND_BYTE);
                        end
                    end
                end
                PH_ESC, PH_HIBSL: begin
                    if (c == CH_U) begin
                        accum_next = '0;
                        phase_next = (phase_reg == PH_ESC) ? PH_HEX0 : PH_PHEX0;
                    end else if (esc[8]) begin
                        if (phase_reg == PH_HIBSL) begin
                            job       = job_add_cp(job, {5'd0, high_reg});
                            high_next = '0;
                        end
                        job        = job_add(job, esc[7:0], KIND_BYTE);
                        phase_next = PH_STR;
                    end else begin
                        err = 1'b1;
                    end
                end
                [PH_HEX0:PH_HEX3], [PH_PHEX0:PH_PHEX3]: begin
                    if (!hd[4]) begin
                        err = 1'b1;
                    end else if (phase_reg == PH_HEX3 || phase_reg == PH_PHEX3) begin
                        accum_next = '0;
                        if (phase_reg == PH_PHEX3 && v >= 16'hDC00 && v <= 16'hDFFF) begin
                            job = job_add_cp(job,
                                21'h10000 + {11'd0, high_reg[9:0]} * 21'd1024
                                          + {11'd0, v[9:0]});
                            high_next  = '0;
                            phase_next = PH_STR;
                        end else begin
                            if (phase_reg == PH_PHEX3) begin
                                job       = job_add_cp(job, {5'd0, high_reg});
                                high_next = '0;
                            end
                            if (v >= 16'hD800 && v <= 16'hDBFF) begin
                                high_next  = v;
                                phase_next = PH_AFTHI;
                            end else begin
                                job        = job_add_cp(job, {5'd0, v});
                                phase_next = PH_STR;
                            end
                        end
                    end else begin
                        accum_next = v;
                        phase_next = phase_reg + 4'd1;
                    end
                end
                default: begin
                    // Idle, and the unused codes treated as idle
                    phase_next = PH_IDLE;
                    if (c == CH_QUOTE) begin
                        accum_next = '0;
                        high_next  = '0;
                        phase_next = PH_STR;
                    end else if (c != 8'h20 && c != 8'h09 && c != 8'h0A && c != 8'h0D) begin
                        err = 1'b1;
                    end
                end
            endcase
        end

        if (err) begin
            // Drop everything pending; the error stands alone
            phase_next = PH_IDLE;
            accum_next = '0;
            high_next  = '0;
            job        = job_add('0, 8'd0, KIND_ERROR);
        end

        push_job = job;
    end

    assign push = fire & (push_job.count != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            accum_reg <= '0;
            high_reg  <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            high_reg  <= high_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/jsu_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output job_t      pop_job,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_Q-1:0] FULL_CNT = CNT_Q'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_Q-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign pop_job = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/jsu_back.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_back
    import jsu_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  q_empty,
    input  wire job_t  q_job,
    output logic       q_pop,
    output logic       m_valid,
    input  wire logic  m_ready,
    output out_item_t  m_data
);

    job_t             cur_reg;
    logic             cur_valid_reg;
    logic [CNT_W-1:0] pos_reg;
    logic             at_last;
    logic             take;

    assign at_last = (pos_reg == cur_reg.count - 1'b1);
    assign take    = cur_valid_reg & m_ready;
    // Refill when no job is held, or as the final result of the current job leaves
    assign q_pop   = ~q_empty & (~cur_valid_reg | (take & at_last));

    assign m_valid            = cur_valid_reg;
    assign m_data.out_byte    = cur_reg.res[pos_reg].data;
    assign m_data.kind        = cur_reg.res[pos_reg].kind;
    assign m_data.last_of_run = at_last;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end else if (q_pop) begin
            cur_valid_reg <= 1'b1;
            pos_reg       <= '0;
        end else if (take) begin
            if (at_last) begin
                cur_valid_reg <= 1'b0;
                pos_reg       <= '0;
            end else begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/json_string_unescape_utf8.sv
// JSON string unescaper with UTF-8 output.
// Input channel (s_valid/s_ready/s_data): one raw byte of JSON text per
// transaction, or an end-of-input marker (at_end). Output channel
// (m_valid/m_ready/m_data): one result per transaction - a decoded byte, a
// string-closed marker or an error marker; last_of_run flags the final
// result caused by one input byte. Bytes that cause no result (whitespace
// before the string, a backslash, the first three hex digits) produce nothing.
// The results of a byte pass through the job queue and the back end's job
// register before they are presented. Throughput: one byte per cycle while
// each byte yields at most one result and the receiver does not stall; a
// byte with several results (up to six: a flushed lone surrogate and a new
// \u value) is sent one result per transaction, and the decoder front keeps
// accepting until the job queue between front and back fills.
// Reset (aresetn low, synchronous): returns to idle, empties the queue and
// drops any result on offer. When the receiver stalls, the current result
// is held stable and input is taken until the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    logic q_push, q_full, q_pop, q_empty;
    job_t q_in_job, q_out_job;

    // Decode: parse state, escapes and UTF-8 encoding of each byte
    jsu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .push     (q_push),
        .push_job (q_in_job)
    );

    // Hold jobs so front and back stall independently
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_in_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_out_job),
        .empty    (q_empty)
    );

    // Serialise each job, one result per transaction
    jsu_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_job   (q_out_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A job is never pushed into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("job pushed into full queue");

    // Done and error markers always close their run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_DONE || m_data.kind == KIND_ERROR)
        |-> m_data.last_of_run)
        else $error("marker not last of run");

    // Markers carry a zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != KIND_BYTE |-> m_data.out_byte == 8'd0)
        else $error("marker with non-zero byte");

    // A result on offer stays until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: tb/tb_json_string_unescape_utf8.sv
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8;
    import jsu_pkg::*;

    // Bytes of JSON syntax the decoder reacts to
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;

    // UTF-16 surrogate ranges
    localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

    localparam int          RANDOM_ITEMS = 480;
    localparam int          HOLD_AT      = 180;   // queue position of the receiver hold-off
    localparam int          DRAIN_AT     = 340;   // queue position of the sender pause
    localparam int          HOLD_CYCLES  = 300;
    localparam int          TAIL_CYCLES  = 20;
    localparam longint      TIMEOUT_NS   = 64'd5_000_000;

    // Decoder position within a JSON string literal
    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_STR        = 4'd1,
        PH_ESC        = 4'd2,
        PH_HEX0       = 4'd3,
        PH_HEX1       = 4'd4,
        PH_HEX2       = 4'd5,
        PH_HEX3       = 4'd6,
        PH_AFTER_HIGH = 4'd7,
        PH_HIGH_BSL   = 4'd8,
        PH_PHEX0      = 4'd9,
        PH_PHEX1      = 4'd10,
        PH_PHEX2      = 4'd11,
        PH_PHEX3      = 4'd12
    } dec_phase_e;

    // One byte of JSON text waiting to be offered, with its pacing
    typedef struct {
        in_item_t    item;
        int unsigned gap_after;   // idle cycles after this transaction
        bit          rx_busy;     // receiver stalls at random while this one is in use
        bit          drain_first; // wait for every decoded result before offering
        bit          hold_rx;     // start the long receiver hold-off
    } json_byte_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    json_byte_t  json_text_q[$];   // JSON text still to be offered
    out_item_t   decoded_q[$];     // decoded results not yet seen on the output
    out_item_t   step_out[$];      // results of the byte being decoded

    // Decoder state mirrored from the block
    dec_phase_e  dec_phase;
    logic [15:0] dec_accum;
    logic [15:0] dec_high;

    // Pacing shared between the two sides
    bit          calm_string;
    bit          rx_busy_string;
    int          calm_left;
    int unsigned tx_gap;
    logic        rx_busy;
    logic [7:0]  hold_token;
    logic [7:0]  hold_seen;
    int unsigned rx_stall;

    int          bytes_sent;
    int          utf8_seen;
    int          closed_seen;
    int          errors_seen;
    int          fail_count;

    json_string_unescape_utf8 DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    // 0..15 for a hex digit of either case; bit 4 set for anything else
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
        return 5'h10;
    endfunction

    // Byte that a simple escape letter stands for; bit 8 set if not one
    function automatic logic [8:0] escape_value(input logic [7:0] c);
        case (c)
            8'h22:   return 9'h022;
            8'h5C:   return 9'h05C;
            8'h2F:   return 9'h02F;
            8'h6E:   return 9'h00A;
            8'h72:   return 9'h00D;
            8'h74:   return 9'h009;
            8'h62:   return 9'h008;
            8'h66:   return 9'h00C;
            default: return 9'h100;
        endcase
    endfunction

    function automatic void push_result(input logic [7:0] b, input logic [1:0] k);
        out_item_t r;
        r.out_byte    = b;
        r.kind        = k;
        r.last_of_run = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void push_codepoint(input logic [20:0] cp);
        if (cp < 21'h80) begin
            push_result(cp[7:0], KIND_BYTE);
        end else if (cp < 21'h800) begin
            push_result(8'hC0 | {3'b000, cp[10:6]}, KIND_BYTE);
            push_result(8'h80 | {2'b00, cp[5:0]}, KIND_BYTE);
        end else if (cp < 21'h10000) begin
            push_result(8'hE0 | {4'h0, cp[15:12]}, KIND_BYTE);
            push_result(8'h80 | {2'b00, cp[11:6]}, KIND_BYTE);
            push_result(8'h80 | {2'b00, cp[5:0]}, KIND_BYTE);
        end else begin
            push_result(8'hF0 | {5'b00000, cp[20:18]}, KIND_BYTE);
            push_result(8'h80 | {2'b00, cp[17:12]}, KIND_BYTE);
            push_result(8'h80 | {2'b00, cp[11:6]}, KIND_BYTE);
            push_result(8'h80 | {2'b00, cp[5:0]}, KIND_BYTE);
        end
    endfunction

    // Complete \u value: park a high surrogate, emit anything else
    function automatic void finish_unicode(input logic [15:0] v);
        if (v >= HIGH_SURR_FIRST && v <= HIGH_SURR_LAST) begin
            dec_high  = v;
            dec_phase = PH_AFTER_HIGH;
        end else begin
            dec_phase = PH_STR;
            push_codepoint({5'd0, v});
        end
    endfunction

    function automatic void clear_decoder();
        dec_phase = PH_IDLE;
        dec_accum = '0;
        dec_high  = '0;
    endfunction

    // Decode one accepted byte and queue whatever it produces
    function automatic void unescape_byte(input in_item_t it);
        logic [7:0]  c;
        logic [8:0]  mapped;
        logic [4:0]  digit;
        logic [15:0] word;
        logic [20:0] paired;
        bit          err;
        c   = it.in_byte;
        err = 1'b0;
        step_out.delete();
        if (it.at_end) begin
            err = 1'b1;
        end else begin
            case (dec_phase)
                PH_STR, PH_AFTER_HIGH: begin
                    if (dec_phase == PH_AFTER_HIGH && c == CH_BSLASH) begin
                        // hold the high surrogate until the escape is known
                        dec_phase = PH_HIGH_BSL;
                    end else begin
                        if (dec_phase == PH_AFTER_HIGH) begin
                            push_codepoint({5'd0, dec_high});
                            dec_high  = '0;
                            dec_phase = PH_STR;
                        end
                        if (c == CH_QUOTE) begin
                            push_result(8'h00, KIND_DONE);
                            dec_phase = PH_IDLE;
                        end else if (c == CH_BSLASH) begin
                            dec_phase = PH_ESC;
                        end else begin
                            push_result(c, KIND_BYTE);
                        end
                    end
                end
                PH_ESC, PH_HIGH_BSL: begin
                    if (c == CH_LOWER_U) begin
                        dec_accum = '0;
                        dec_phase = (dec_phase == PH_ESC) ? PH_HEX0 : PH_PHEX0;
                    end else begin
                        mapped = escape_value(c);
                        if (mapped[8]) begin
                            err = 1'b1;
                        end else begin
                            if (dec_phase == PH_HIGH_BSL) begin
                                push_codepoint({5'd0, dec_high});
                                dec_high = '0;
                            end
                            push_result(mapped[7:0], KIND_BYTE);
                            dec_phase = PH_STR;
                        end
                    end
                end
                PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3,
                PH_PHEX0, PH_PHEX1, PH_PHEX2, PH_PHEX3: begin
                    digit = hex_value(c);
                    if (digit[4]) begin
                        err = 1'b1;
                    end else begin
                        word = {dec_accum[11:0], digit[3:0]};
                        if (dec_phase == PH_HEX3) begin
                            dec_accum = '0;
                            finish_unicode(word);
                        end else if (dec_phase == PH_PHEX3) begin
                            dec_accum = '0;
                            if (word >= LOW_SURR_FIRST && word <= LOW_SURR_LAST) begin
                                paired = SUPPLEMENTARY_BASE
                                       + (21'(dec_high - HIGH_SURR_FIRST) << 10)
                                       + 21'(word - LOW_SURR_FIRST);
                                dec_high  = '0;
                                dec_phase = PH_STR;
                                push_codepoint(paired);
                            end else begin
                                // lone high surrogate: flush it, then take the new value
                                push_codepoint({5'd0, dec_high});
                                dec_high = '0;
                                finish_unicode(word);
                            end
                        end else begin
                            dec_accum = word;
                            dec_phase = dec_phase_e'(dec_phase + 4'd1);
                        end
                    end
                end
                default: begin
                    // idle, and any unused phase code behaves as idle
                    dec_phase = PH_IDLE;
                    if (c == CH_QUOTE) begin
                        dec_accum = '0;
                        dec_high  = '0;
                        dec_phase = PH_STR;
                    end else if (c != CH_SPACE && c != CH_TAB && c != CH_LF && c != CH_CR) begin
                        err = 1'b1;
                    end
                end
            endcase
        end
        if (err) begin
            // an error discards everything else this byte would have produced
            clear_decoder();
            step_out.delete();
            push_result(8'h00, KIND_ERROR);
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
        foreach (step_out[i]) decoded_q.push_back(step_out[i]);
    endfunction

    // ------------------------------------------------------------------
    // JSON text generation
    // ------------------------------------------------------------------

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(12, 4);
        return $urandom_range(40, 20);
    endfunction

    function automatic void push_raw(input logic [7:0] b, input bit eob = 1'b0);
        json_byte_t e;
        e.item.in_byte = b;
        e.item.at_end  = eob;
        e.rx_busy      = rx_busy_string;
        e.drain_first  = (json_text_q.size() == DRAIN_AT);
        e.hold_rx      = (json_text_q.size() == HOLD_AT);
        // keep the sender flat out while the receiver is held off
        if (e.hold_rx) calm_left = 60;
        e.gap_after = (calm_string || calm_left > 0) ? 0 : idle_len();
        if (calm_left > 0) calm_left--;
        json_text_q.push_back(e);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (($urandom_range(1) != 0) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic void push_unicode_escape(input logic [15:0] v);
        push_raw(CH_BSLASH);
        push_raw(CH_LOWER_U);
        for (int i = 3; i >= 0; i--) push_raw(hex_char(v[i*4 +: 4]));
    endfunction

    // Endpoints of a range turn up often
    function automatic logic [15:0] pick_code(input logic [15:0] lo, input logic [15:0] hi);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return lo;
        if (r < 20) return hi;
        return 16'($urandom_range(hi, lo));
    endfunction

    function automatic logic [7:0] pick_whitespace();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // Bytes that end up as string content
    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] pick_escape_letter();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (escape_value(c) > 9'h0FF);
        return c;
    endfunction

    function automatic logic [7:0] pick_bad_escape();
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while (escape_value(c) <= 9'h0FF || c == CH_LOWER_U);
        return c;
    endfunction

    function automatic logic [7:0] pick_bad_hex();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (hex_value(c) != 5'h10);
        return c;
    endfunction

    function automatic logic [7:0] pick_idle_noise();
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while (c == CH_QUOTE || c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR);
        return c;
    endfunction

    // A well-formed string literal with random content, sometimes broken at the end
    function automatic void push_json_string();
        int unsigned segs;
        int unsigned r;
        int unsigned good_digits;
        calm_string    = ($urandom_range(3) == 0);
        rx_busy_string = ($urandom_range(3) != 0);
        repeat ($urandom_range(2)) push_raw(pick_whitespace());
        push_raw(CH_QUOTE);
        segs = $urandom_range(6, 1);
        repeat (segs) begin
            r = $urandom_range(99);
            if (r < 30) begin
                push_raw(pick_plain());
            end else if (r < 45) begin
                push_raw(CH_BSLASH);
                push_raw(pick_escape_letter());
            end else if (r < 55) begin
                push_unicode_escape(pick_code(16'h0000, 16'h007F));
            end else if (r < 62) begin
                push_unicode_escape(pick_code(16'h0080, 16'h07FF));
            end else if (r < 70) begin
                if ($urandom_range(1) != 0) push_unicode_escape(pick_code(16'h0800, 16'hD7FF));
                else push_unicode_escape(pick_code(16'hE000, 16'hFFFF));
            end else if (r < 80) begin
                push_unicode_escape(pick_code(HIGH_SURR_FIRST, HIGH_SURR_LAST));
                push_unicode_escape(pick_code(LOW_SURR_FIRST, LOW_SURR_LAST));
            end else if (r < 89) begin
                // lone high: whatever the next segment is decides its fate
                push_unicode_escape(pick_code(HIGH_SURR_FIRST, HIGH_SURR_LAST));
            end else if (r < 93) begin
                push_unicode_escape(pick_code(LOW_SURR_FIRST, LOW_SURR_LAST));
            end else begin
                push_raw(8'($urandom_range(255, 128)));
            end
        end
        r = $urandom_range(99);
        if (r < 84) begin
            push_raw(CH_QUOTE);
        end else if (r < 89) begin
            push_raw(CH_BSLASH);
            push_raw(pick_bad_escape());
        end else if (r < 94) begin
            push_raw(CH_BSLASH);
            push_raw(CH_LOWER_U);
            good_digits = $urandom_range(3);
            repeat (good_digits) push_raw(hex_char(4'($urandom_range(15))));
            push_raw(pick_bad_hex());
        end else begin
            push_raw(8'($urandom_range(255)), 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side: offer the queued JSON text, predict on every transaction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_data     <= '0;
            tx_gap     <= 0;
            rx_busy    <= 1'b0;
            hold_token <= '0;
        end else begin
            if (s_valid && s_ready) begin
                unescape_byte(s_data);
                bytes_sent++;
            end
            // the slot is free once nothing is on offer or the offer was just taken
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap  <= tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (json_text_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (json_text_q[0].drain_first && decoded_q.size() != 0) begin
                    // hold off until every decoded result has come out
                    s_valid <= 1'b0;
                end else begin
                    s_data  <= json_text_q[0].item;
                    s_valid <= 1'b1;
                    tx_gap  <= json_text_q[0].gap_after;
                    rx_busy <= json_text_q[0].rx_busy;
                    if (json_text_q[0].hold_rx) hold_token <= hold_token + 8'd1;
                    void'(json_text_q.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: pace m_ready and check each result transaction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : rx_side
        out_item_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            rx_stall  <= 0;
            hold_seen <= '0;
        end else begin
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result: byte=%02h kind=%0d last=%0b", $time,
                             m_data.out_byte, m_data.kind, m_data.last_of_run);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_data.out_byte !== want.out_byte || m_data.kind !== want.kind ||
                        m_data.last_of_run !== want.last_of_run) begin
                        fail_count++;
                        $display("%0t: mismatch: expected byte=%02h kind=%0d last=%0b, got byte=%02h kind=%0d last=%0b",
                                 $time, want.out_byte, want.kind, want.last_of_run,
                                 m_data.out_byte, m_data.kind, m_data.last_of_run);
                    end
                    case (want.kind)
                        KIND_BYTE: utf8_seen++;
                        KIND_DONE: closed_seen++;
                        default:   errors_seen++;
                    endcase
                end
            end
            if (hold_token != hold_seen) begin
                // long hold-off so the block fills up and stalls its input
                hold_seen <= hold_token;
                rx_stall  <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
                m_ready  <= 1'b0;
            end else if (rx_busy && $urandom_range(99) < 35) begin
                rx_stall <= idle_len();
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int target;
        int unsigned r;
        clear_decoder();
        calm_string    = 1'b0;
        rx_busy_string = 1'b1;
        calm_left      = 0;
        bytes_sent     = 0;
        utf8_seen      = 0;
        closed_seen    = 0;
        errors_seen    = 0;
        fail_count     = 0;

        // Directed opening: idle errors, whitespace, extreme raw bytes,
        // the largest surrogate pair, an escaped zero and a bad escape
        push_raw(8'hFF, 1'b1);
        push_raw(8'h41);
        push_raw(CH_SPACE);
        push_raw(CH_TAB);
        push_raw(CH_LF);
        push_raw(CH_CR);
        push_raw(CH_QUOTE);
        push_raw(8'h00);
        push_raw(8'hFF);
        push_unicode_escape(HIGH_SURR_LAST);
        push_unicode_escape(LOW_SURR_LAST);
        push_unicode_escape(16'h0000);
        push_raw(CH_BSLASH);
        push_raw(8'h71);

        // Random part: mostly well-formed strings, some idle noise
        target = json_text_q.size() + RANDOM_ITEMS;
        while (json_text_q.size() < target) begin
            r = $urandom_range(99);
            if (r < 4) begin
                push_raw(8'($urandom_range(255)), 1'b1);
            end else if (r < 8) begin
                push_raw(pick_idle_noise());
            end else begin
                push_json_string();
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain: wait for the text to go in and every result to come out
        while (json_text_q.size() != 0 || s_valid || decoded_q.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (decoded_q.size() != 0) begin
            fail_count++;
            $display("%0t: %0d decoded results never arrived", $time, decoded_q.size());
        end

        $display("Covered %0d JSON bytes in, %0d results checked: %0d UTF-8 bytes,",
                 bytes_sent, utf8_seen + closed_seen + errors_seen, utf8_seen);
        $display("  %0d strings closed, %0d syntax errors; %0d mismatches",
                 closed_seen, errors_seen, fail_count);
        if (fail_count == 0) begin
            $display("json_string_unescape_utf8 regression: pass");
        end else begin
            $display("json_string_unescape_utf8 regression: fail");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d results outstanding", $time, decoded_q.size());
        $display("json_string_unescape_utf8 regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
tb/tb_json_string_unescape_utf8.sv
